// File: rtl/core/x86ilf_pkg.sv
package x86ilf_pkg;

    // instruction assembly phase
    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_MODRM  = 2'd1,
        PH_DISP   = 2'd2,
        PH_IMM    = 2'd3
    } phase_t;

    // segment override codes
    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_CS   = 3'd1;
    localparam logic [2:0] SEG_DS   = 3'd2;
    localparam logic [2:0] SEG_ES   = 3'd3;
    localparam logic [2:0] SEG_SS   = 3'd4;
    localparam logic [2:0] SEG_FS   = 3'd5;
    localparam logic [2:0] SEG_GS   = 3'd6;

    // prefix bytes
    localparam logic [7:0] PFX_CS    = 8'h2e;
    localparam logic [7:0] PFX_DS    = 8'h3e;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_REPNE = 8'hf2;
    localparam logic [7:0] PFX_REPE  = 8'hf3;
    localparam logic [7:0] PFX_LOCK  = 8'hf0;

    // modrm field masks
    localparam logic [7:0] MODRM_REG_MASK = 8'h38;
    localparam logic [7:0] MODRM_MOD_MASK = 8'hc0;
    localparam logic [2:0] RM_DIRECT      = 3'h6;

    localparam logic [7:0] COUNT_MAX = 8'hff;

    // bit n set: opcode n is followed by a modrm byte
    localparam logic [255:0] MODRM_MAP = {
        32'hC0C00000, 32'h000F00F3, 32'h00000000, 32'h0000FFFF,
        32'h00000A0C, 32'h00000000, 32'h0F0F0F0F, 32'h0F0F0F0F
    };

    // output payload layout
    localparam int OUT_BITS = 115;
    localparam int OUT_DATA_W = 120;
    localparam int IN_DATA_W = 40;

    function automatic logic has_modrm(input logic [7:0] op);
        return MODRM_MAP[op];
    endfunction

    function automatic logic [1:0] disp_len_of(input logic [7:0] op, input logic [7:0] m);
        logic [1:0] sz;
        sz = 2'd0;
        if (op >= 8'ha0 && op <= 8'ha3) begin
            sz = 2'd2;
        end
        else if (has_modrm(op)) begin
            unique case (m[7:6])
                2'b00:   sz = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
                2'b01:   sz = 2'd1;
                2'b10:   sz = 2'd2;
                default: sz = 2'd0;
            endcase
        end
        return sz;
    endfunction

    function automatic logic [2:0] imm_len_of(input logic [7:0] op, input logic [7:0] m);
        logic [2:0] sz;
        sz = 3'd0;
        if (op >= 8'h70 && op <= 8'h7f) begin
            sz = 3'd1;
        end
        else if (op >= 8'hb0 && op <= 8'hb7) begin
            sz = 3'd1;
        end
        else if (op >= 8'hb8 && op <= 8'hbf) begin
            sz = 3'd2;
        end
        else begin
            unique case (op)
                8'h04, 8'h0c, 8'h14, 8'h1c, 8'h24, 8'h2c, 8'h34, 8'h3c,
                8'h6a, 8'h6b, 8'h80, 8'h82, 8'h83, 8'ha8, 8'hc0, 8'hc1,
                8'hc6, 8'hcd, 8'hd4, 8'hd5, 8'he0, 8'he1, 8'he2, 8'he3,
                8'he4, 8'he5, 8'he6, 8'he7, 8'heb:
                    sz = 3'd1;
                8'h05, 8'h0d, 8'h15, 8'h1d, 8'h25, 8'h2d, 8'h35, 8'h3d,
                8'h68, 8'h69, 8'h81, 8'ha9, 8'hc2, 8'hc7, 8'hca, 8'he8,
                8'he9:
                    sz = 3'd2;
                8'h9a, 8'hea:
                    sz = 3'd4;
                8'hf6:
                    sz = ((m & MODRM_REG_MASK) == 8'h00) ? 3'd1 : 3'd0;
                8'hf7:
                    sz = ((m & MODRM_REG_MASK) == 8'h00) ? 3'd2 : 3'd0;
                default:
                    sz = 3'd0;
            endcase
        end
        return sz;
    endfunction

endpackage

// File: rtl/core/x86_instruction_length_fetcher_top.sv
// Assembles 16-bit-mode 8086-style instructions from a stream of code bytes, one byte per
// transaction on the slave side, and emits one transaction on the master side per complete
// instruction: prefixes seen (last segment override wins), opcode, modrm, displacement and
// immediate (little-endian, zero-extended) with their lengths, the address of the first byte
// and the total length saturating at 255. The decode of the incoming byte against the held
// instruction state is short combinational logic into the state and result registers, so
// one byte is taken per cycle while the slave side does not stall; the result appears on the
// master side the cycle after its last byte, and the slave side stalls only when the result
// register is full and the master side is not ready.
module x86_instruction_length_fetcher_top
    import x86ilf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // code_byte [7:0], byte_address [39:8]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // segment_override [2:0], repne_seen [3], repe_seen [4], lock_seen [5],
    // opcode_byte [13:6], modrm_byte [21:14], displacement [37:22], disp_length [39:38],
    // immediate [71:40], imm_length [74:72], start_address [106:75], total_length [114:107]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    phase_t      phase_reg, phase_next, phase_upd;
    logic [2:0]  seg_reg, seg_next, seg_upd;
    logic [2:0]  flags_reg, flags_next, flags_upd;
    logic [7:0]  op_reg, op_next, op_upd;
    logic [7:0]  modrm_reg, modrm_next, modrm_upd;
    logic [15:0] disp_acc_reg, disp_acc_next, disp_acc_upd;
    logic [1:0]  disp_need_reg, disp_need_next, disp_need_upd;
    logic [1:0]  disp_got_reg, disp_got_next, disp_got_upd;
    logic [31:0] imm_acc_reg, imm_acc_next, imm_acc_upd;
    logic [2:0]  imm_need_reg, imm_need_next, imm_need_upd;
    logic [2:0]  imm_got_reg, imm_got_next, imm_got_upd;
    logic [31:0] first_reg, first_next, first_upd;
    logic [7:0]  count_reg, count_next, count_upd;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        s_accept;
    logic        done;
    logic [7:0]  code_byte;
    logic [31:0] byte_address;
    logic [7:0]  dec_op, dec_modrm;
    logic [1:0]  dec_disp;
    logic [2:0]  dec_imm;
    logic        dec_sel;

    assign code_byte    = s_tdata[7:0];
    assign byte_address = s_tdata[39:8];
    assign s_tready     = !out_valid_reg || m_tready;
    assign s_accept     = s_tvalid && s_tready;

    // length decode for the opcode/modrm pair being finished this byte
    always_comb
    begin
        dec_op    = (phase_reg == PH_MODRM) ? op_reg : code_byte;
        dec_modrm = (phase_reg == PH_MODRM) ? code_byte : modrm_reg;
        dec_disp  = disp_len_of(dec_op, dec_modrm);
        dec_imm   = imm_len_of(dec_op, dec_modrm);
    end

    // update of the instruction state by the incoming byte
    always_comb
    begin
        phase_upd     = phase_reg;
        seg_upd       = seg_reg;
        flags_upd     = flags_reg;
        op_upd        = op_reg;
        modrm_upd     = modrm_reg;
        disp_acc_upd  = disp_acc_reg;
        disp_need_upd = disp_need_reg;
        disp_got_upd  = disp_got_reg;
        imm_acc_upd   = imm_acc_reg;
        imm_need_upd  = imm_need_reg;
        imm_got_upd   = imm_got_reg;
        dec_sel       = 1'b0;
        done          = 1'b0;

        first_upd = (phase_reg == PH_PREFIX && count_reg == 8'd0) ? byte_address : first_reg;
        count_upd = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                unique case (code_byte)
                    PFX_CS:    seg_upd = SEG_CS;
                    PFX_DS:    seg_upd = SEG_DS;
                    PFX_ES:    seg_upd = SEG_ES;
                    PFX_SS:    seg_upd = SEG_SS;
                    PFX_FS:    seg_upd = SEG_FS;
                    PFX_GS:    seg_upd = SEG_GS;
                    PFX_REPNE: flags_upd = flags_reg | 3'b001;
                    PFX_REPE:  flags_upd = flags_reg | 3'b010;
                    PFX_LOCK:  flags_upd = flags_reg | 3'b100;
                    default:
                    begin
                        op_upd = code_byte;
                        if (has_modrm(code_byte))
                        begin
                            phase_upd = PH_MODRM;
                        end
                        else
                        begin
                            dec_sel = 1'b1;
                        end
                    end
                endcase
            end
            PH_MODRM:
            begin
                modrm_upd = code_byte;
                dec_sel   = 1'b1;
            end
            PH_DISP:
            begin
                disp_acc_upd = disp_acc_reg | (disp_got_reg[0] ? {code_byte, 8'h00}
                                                               : {8'h00, code_byte});
                disp_got_upd = disp_got_reg + 2'd1;
                if (disp_got_upd >= disp_need_reg)
                begin
                    if (imm_need_reg != 3'd0)
                    begin
                        phase_upd = PH_IMM;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            PH_IMM:
            begin
                imm_acc_upd = imm_acc_reg
                            | ({24'h000000, code_byte} << {imm_got_reg[1:0], 3'b000});
                imm_got_upd = imm_got_reg + 3'd1;
                if (imm_got_upd >= imm_need_reg)
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                phase_upd = PH_PREFIX;
            end
        endcase

        // opcode and modrm known: pick the operand phase
        if (dec_sel)
        begin
            disp_need_upd = dec_disp;
            imm_need_upd  = dec_imm;
            if (dec_disp != 2'd0)
            begin
                phase_upd = PH_DISP;
            end
            else if (dec_imm != 3'd0)
            begin
                phase_upd = PH_IMM;
            end
            else
            begin
                done = 1'b1;
            end
        end
    end

    // next state: hold when idle, clear after a finished instruction
    always_comb
    begin
        phase_next     = phase_reg;
        seg_next       = seg_reg;
        flags_next     = flags_reg;
        op_next        = op_reg;
        modrm_next     = modrm_reg;
        disp_acc_next  = disp_acc_reg;
        disp_need_next = disp_need_reg;
        disp_got_next  = disp_got_reg;
        imm_acc_next   = imm_acc_reg;
        imm_need_next  = imm_need_reg;
        imm_got_next   = imm_got_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        if (s_accept && done)
        begin
            phase_next     = PH_PREFIX;
            seg_next       = SEG_NONE;
            flags_next     = 3'b000;
            op_next        = 8'h00;
            modrm_next     = 8'h00;
            disp_acc_next  = 16'h0000;
            disp_need_next = 2'd0;
            disp_got_next  = 2'd0;
            imm_acc_next   = 32'h00000000;
            imm_need_next  = 3'd0;
            imm_got_next   = 3'd0;
            first_next     = 32'h00000000;
            count_next     = 8'd0;
        end
        else if (s_accept)
        begin
            phase_next     = phase_upd;
            seg_next       = seg_upd;
            flags_next     = flags_upd;
            op_next        = op_upd;
            modrm_next     = modrm_upd;
            disp_acc_next  = disp_acc_upd;
            disp_need_next = disp_need_upd;
            disp_got_next  = disp_got_upd;
            imm_acc_next   = imm_acc_upd;
            imm_need_next  = imm_need_upd;
            imm_got_next   = imm_got_upd;
            first_next     = first_upd;
            count_next     = count_upd;
        end
    end

    // result register: load on a finished instruction, drain on master transaction
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (s_accept && done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, count_upd, first_upd,
                              imm_need_upd, imm_acc_upd, disp_need_upd, disp_acc_upd,
                              modrm_upd, op_upd, flags_upd[2], flags_upd[1], flags_upd[0],
                              seg_upd};
        end
    end

    // control and instruction state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            seg_reg       <= SEG_NONE;
            flags_reg     <= 3'b000;
            op_reg        <= 8'h00;
            modrm_reg     <= 8'h00;
            disp_acc_reg  <= 16'h0000;
            disp_need_reg <= 2'd0;
            disp_got_reg  <= 2'd0;
            imm_acc_reg   <= 32'h00000000;
            imm_need_reg  <= 3'd0;
            imm_got_reg   <= 3'd0;
            first_reg     <= 32'h00000000;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seg_reg       <= seg_next;
            flags_reg     <= flags_next;
            op_reg        <= op_next;
            modrm_reg     <= modrm_next;
            disp_acc_reg  <= disp_acc_next;
            disp_need_reg <= disp_need_next;
            disp_got_reg  <= disp_got_next;
            imm_acc_reg   <= imm_acc_next;
            imm_need_reg  <= imm_need_next;
            imm_got_reg   <= imm_got_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
